FILE: rtl/ti_pkg.sv
// shared types, constants and helpers of the table interpolator
`default_nettype none

package ti_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 7;
  localparam int VALUE_W     = 32;
  localparam int FRAC_W      = 17;
  localparam int FRAC_BITS   = 16;
  localparam int RES_W       = VALUE_W + 2;
  localparam int MUL_W       = 2 * VALUE_W + 2;

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1 << FRAC_BITS);

  localparam int DIV_NUM_W = 2 * VALUE_W;
  localparam int DIV_DEN_W = VALUE_W;
  localparam int DIV_QUO_W = VALUE_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_QUO_W + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam int NUM_REGS = 5;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int PADDR_W  = REG_IDX_W + 2;
  localparam int PDATA_W  = 32;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_POINT_COUNT   = 3'd0,
    REG_INTERP_MODE   = 3'd1,
    REG_BELOW_VALUE   = 3'd2,
    REG_ABOVE_VALUE   = 3'd3,
    REG_STEP_FRACTION = 3'd4
  } reg_e;

  typedef enum logic [1:0] {
    STATUS_IN_RANGE = 2'd0,
    STATUS_BELOW    = 2'd1,
    STATUS_ABOVE    = 2'd2,
    STATUS_EMPTY    = 2'd3
  } status_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef struct packed {
    logic                      cmd;
    logic [5:0]                point_index;
    logic signed [VALUE_W-1:0] point_x;
    logic signed [VALUE_W-1:0] point_y;
    logic signed [VALUE_W-1:0] query_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] interp_value;
    logic [1:0]                status;
  } out_item_t;

  typedef struct packed {
    op_e                       kind;
    logic [IDX_W-1:0]          slot;
    logic signed [VALUE_W-1:0] x;
    logic signed [VALUE_W-1:0] y;
  } op_t;

  typedef struct packed {
    logic [CNT_W-1:0]          point_count;
    logic                      interp_mode;
    logic signed [VALUE_W-1:0] below_value;
    logic signed [VALUE_W-1:0] above_value;
    logic [FRAC_W-1:0]         step_fraction;
  } cfg_t;

  function automatic logic signed [RES_W-1:0] sext_res(input logic [VALUE_W-1:0] v);
    sext_res = $signed({{(RES_W-VALUE_W){v[VALUE_W-1]}}, v});
  endfunction

  // clamp to the signed value range
  function automatic logic signed [VALUE_W-1:0] sat_res(input logic [RES_W-1:0] r);
    logic fits;
    fits = (r[RES_W-1:VALUE_W-1] == '0) || (r[RES_W-1:VALUE_W-1] == '1);
    if (fits) begin
      sat_res = $signed(r[VALUE_W-1:0]);
    end else if (r[RES_W-1]) begin
      sat_res = $signed({1'b1, {(VALUE_W-1){1'b0}}});
    end else begin
      sat_res = $signed({1'b0, {(VALUE_W-1){1'b1}}});
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/table_interpolator.sv
// Breakpoint-table interpolator with bisection search.
// Input channel (in_valid_i/in_ready_o, in_data_i): cmd 0 loads one point into
// slot point_index, cmd 1 queries the table at query_value. A four-entry queue
// takes transactions while the execution side works, so the input only stalls
// when that queue is full. Output channel (out_valid_o/out_ready_i,
// out_data_o) gives one result per query and none per load, in order.
// A load is written into the table from the idle state. A query reads the first
// and last point, checks the bounds, runs the bisection (up to 6 steps for 64
// points), reads the two y values, then computes the result in constant mode,
// or in linear mode with the one-bit-a-cycle divider (33 quotient bits), and
// hands the result over; out-of-range queries go to the hand-over from the
// bounds check, empty-table queries straight from idle.
// When the receiver stalls the result waits in the output register; the next
// query runs up to its result and holds there, and the transactions behind it
// wait in the queue until it fills and the input stalls.
// Reset clears the registers and queue; the table is undefined until loaded.
// The register port is APB with pready always high: point_count, interp_mode,
// below_value, above_value and step_fraction at byte offsets 0, 4, 8, 12, 16.
`default_nettype none

module table_interpolator (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire ti_pkg::in_item_t           in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output ti_pkg::out_item_t               out_data_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ti_pkg::PADDR_W-1:0] paddr,
  input  wire logic [ti_pkg::PDATA_W-1:0] pwdata,
  output logic [ti_pkg::PDATA_W-1:0]      prdata,
  output logic                            pready
);
  import ti_pkg::*;

  cfg_t  cfg_q;
  logic  wr;
  reg_e  reg_sel;
  logic  head_valid;
  op_t   head;
  logic  pop;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_sel = reg_e'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr) begin
      case (reg_sel)
        REG_POINT_COUNT:   cfg_q.point_count   <= pwdata[CNT_W-1:0];
        REG_INTERP_MODE:   cfg_q.interp_mode   <= pwdata[0];
        REG_BELOW_VALUE:   cfg_q.below_value   <= $signed(pwdata[VALUE_W-1:0]);
        REG_ABOVE_VALUE:   cfg_q.above_value   <= $signed(pwdata[VALUE_W-1:0]);
        REG_STEP_FRACTION: cfg_q.step_fraction <= pwdata[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_POINT_COUNT:   prdata = PDATA_W'(cfg_q.point_count);
      REG_INTERP_MODE:   prdata = PDATA_W'(cfg_q.interp_mode);
      REG_BELOW_VALUE:   prdata = PDATA_W'(cfg_q.below_value);
      REG_ABOVE_VALUE:   prdata = PDATA_W'(cfg_q.above_value);
      REG_STEP_FRACTION: prdata = PDATA_W'(cfg_q.step_fraction);
      default:           prdata = '0;
    endcase
  end

  ti_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .head_valid_o(head_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  ti_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: rtl/ti_front.sv
// input stage: classifies items and queues them for the execution side
`default_nettype none

module ti_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire ti_pkg::in_item_t in_data_i,
  output logic                 head_valid_o,
  output ti_pkg::op_t          head_o,
  input  wire logic            pop_i
);
  import ti_pkg::*;

  op_t               queue_q [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] count_q, count_d;
  logic               push, pop;
  op_t                op;

  // decode: loads carry the point, queries carry the abscissa in x
  always_comb begin
    op      = '0;
    op.slot = in_data_i.point_index[IDX_W-1:0];
    if (in_data_i.cmd == OP_QUERY) begin
      op.kind = OP_QUERY;
      op.x    = in_data_i.query_value;
    end else begin
      op.kind = OP_LOAD;
      op.x    = in_data_i.point_x;
      op.y    = in_data_i.point_y;
    end
  end

  assign in_ready_o   = (count_q != Q_CNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = queue_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= op;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ti_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module ti_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [ti_pkg::DIV_NUM_W-1:0] num_i,
  input  wire logic [ti_pkg::DIV_DEN_W-1:0] den_i,
  output logic                              done_o,
  output logic [ti_pkg::DIV_QUO_W-1:0]      quot_o
);
  import ti_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_QUO_W-1:0] sh_q;
  logic [DIV_DEN_W:0]   trial;
  logic                 ge;

  always_comb begin
    trial = {rem_q, sh_q[DIV_QUO_W-1]};
    ge    = (trial >= {1'b0, den_q});
    rem_d = ge ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_QUO_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // the quotient is known to fit, so the upper numerator bits start as remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DIV_DEN_W'(num_i[DIV_NUM_W-1:DIV_QUO_W]);
      sh_q  <= num_i[DIV_QUO_W-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= {sh_q[DIV_QUO_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = sh_q;

endmodule

`default_nettype wire

FILE: rtl/ti_back.sv
// execution side: breakpoint memories, bisection search and interpolation
`default_nettype none

module ti_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ti_pkg::cfg_t      cfg_i,
  input  wire logic              head_valid_i,
  input  wire ti_pkg::op_t       head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output ti_pkg::out_item_t      out_data_o
);
  import ti_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_RD0   = 15'b000000000000010,
    S_RDL   = 15'b000000000000100,
    S_BIS   = 15'b000000000001000,
    S_BCMP  = 15'b000000000010000,
    S_YI    = 15'b000000000100000,
    S_YJ    = 15'b000000001000000,
    S_PREP  = 15'b000000010000000,
    S_MUL   = 15'b000000100000000,
    S_NUMST = 15'b000001000000000,
    S_DIV   = 15'b000010000000000,
    S_STEP1 = 15'b000100000000000,
    S_STEP2 = 15'b001000000000000,
    S_STEP3 = 15'b010000000000000,
    S_DONE  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  logic [VALUE_W-1:0] mem_x [TABLE_DEPTH];
  logic [VALUE_W-1:0] mem_y [TABLE_DEPTH];
  logic [VALUE_W-1:0] rd_x, rd_y;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;

  logic signed [VALUE_W-1:0] v_q, xi_q, xj_q, yi_q, yj_q;
  logic signed [VALUE_W-1:0] rdx_s;
  logic [IDX_W-1:0]          nl_q, i_q, j_q, mid_q;
  logic signed [VALUE_W:0]   dx_q, dv_q, dy_q;
  logic [VALUE_W:0]          mag_q;
  logic                      neg_q;
  logic signed [MUL_W-1:0]   prod_q, p1_q, mul_p, step_sum;
  logic signed [VALUE_W:0]   mul_a, mul_b;
  logic signed [RES_W-1:0]   res_q;
  status_e                   status_q;
  logic                      out_valid_q;
  out_item_t                 out_q;

  logic [CNT_W-1:0]     n_clamp;
  logic [CNT_W-1:0]     n_m1;
  logic [FRAC_W-1:0]    fc;
  logic [IDX_W:0]       ij_sum;
  logic                 more_steps;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_NUM_W-1:0] lin_base;
  logic                 div_start;
  logic                 div_done;
  logic [DIV_QUO_W-1:0] div_quot;
  logic signed [RES_W-1:0] q_ext;
  logic                 out_free;

  assign n_clamp  = (cfg_i.point_count > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                               : cfg_i.point_count;
  assign n_m1     = n_clamp - 1'b1;
  assign fc       = (cfg_i.step_fraction > FRAC_ONE) ? FRAC_ONE : cfg_i.step_fraction;
  assign ij_sum   = {1'b0, i_q} + {1'b0, j_q};
  assign more_steps = ({1'b0, i_q} + 1'b1) < {1'b0, j_q};
  assign rdx_s    = $signed(rd_x);
  assign out_free = !out_valid_q || out_ready_i;

  // numerator of the rounded step, |dy| = 2^VALUE_W handled as a shift
  assign lin_base = mag_q[VALUE_W] ? {dv_q[VALUE_W-1:0], {VALUE_W{1'b0}}}
                                   : prod_q[DIV_NUM_W-1:0];
  assign div_num  = lin_base + DIV_NUM_W'(dx_q[VALUE_W-1:1]);
  assign q_ext    = $signed(RES_W'(div_quot));
  assign step_sum = p1_q + prod_q + MUL_W'(1 << (FRAC_BITS - 1));

  // shared multiplier
  always_comb begin
    mul_a = $signed({1'b0, mag_q[VALUE_W-1:0]});
    mul_b = $signed({1'b0, dv_q[VALUE_W-1:0]});
    if (state_q == S_STEP1) begin
      mul_a = $signed({yi_q[VALUE_W-1], yi_q});
      mul_b = $signed({{(VALUE_W+1-FRAC_W){1'b0}}, FRAC_ONE - fc});
    end else if (state_q == S_STEP2) begin
      mul_a = $signed({yj_q[VALUE_W-1], yj_q});
      mul_b = $signed({{(VALUE_W+1-FRAC_W){1'b0}}, fc});
    end
    mul_p = mul_a * mul_b;
  end

  ti_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (dx_q[VALUE_W-1:0]),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    wr_en     = 1'b0;
    rd_addr   = '0;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (head_valid_i) begin
          pop_o = 1'b1;
          if (head_i.kind == OP_LOAD) begin
            wr_en = 1'b1;
          end else if (n_clamp == '0) begin
            state_d = S_DONE;
          end else begin
            state_d = S_RD0;
          end
        end
      end
      S_RD0: begin
        rd_addr = n_m1[IDX_W-1:0];
        state_d = S_RDL;
      end
      S_RDL: begin
        if (v_q < xi_q || v_q > rdx_s) begin
          state_d = S_DONE;
        end else begin
          state_d = S_BIS;
        end
      end
      S_BIS: begin
        if (more_steps) begin
          rd_addr = ij_sum[IDX_W:1];
          state_d = S_BCMP;
        end else begin
          rd_addr = i_q;
          state_d = S_YI;
        end
      end
      S_BCMP: state_d = S_BIS;
      S_YI: begin
        rd_addr = j_q;
        state_d = S_YJ;
      end
      S_YJ: state_d = S_PREP;
      S_PREP: begin
        if (v_q == xj_q || v_q == xi_q) begin
          state_d = S_DONE;
        end else if (cfg_i.interp_mode) begin
          state_d = S_STEP1;
        end else if (dx_q <= 0 || dv_q < 0 || dv_q > dx_q) begin
          state_d = S_DONE;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL:   state_d = S_NUMST;
      S_NUMST: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_DONE;
        end
      end
      S_STEP1: state_d = S_STEP2;
      S_STEP2: state_d = S_STEP3;
      S_STEP3: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        v_q      <= head_i.x;
        nl_q     <= n_m1[IDX_W-1:0];
        res_q    <= '0;
        status_q <= STATUS_EMPTY;
      end
      S_RD0: xi_q <= rdx_s;
      S_RDL: begin
        xj_q <= rdx_s;
        i_q  <= '0;
        j_q  <= nl_q;
        if (v_q < xi_q) begin
          res_q    <= sext_res(cfg_i.below_value);
          status_q <= STATUS_BELOW;
        end else if (v_q > rdx_s) begin
          res_q    <= sext_res(cfg_i.above_value);
          status_q <= STATUS_ABOVE;
        end else begin
          status_q <= STATUS_IN_RANGE;
        end
      end
      S_BIS: mid_q <= ij_sum[IDX_W:1];
      S_BCMP: begin
        if (v_q < rdx_s) begin
          j_q  <= mid_q;
          xj_q <= rdx_s;
        end else begin
          i_q  <= mid_q;
          xi_q <= rdx_s;
        end
      end
      S_YI: yi_q <= $signed(rd_y);
      S_YJ: begin
        yj_q <= $signed(rd_y);
        dx_q <= {xj_q[VALUE_W-1], xj_q} - {xi_q[VALUE_W-1], xi_q};
        dv_q <= {v_q[VALUE_W-1], v_q} - {xi_q[VALUE_W-1], xi_q};
        dy_q <= $signed({rd_y[VALUE_W-1], rd_y}) - {yi_q[VALUE_W-1], yi_q};
      end
      S_PREP: begin
        neg_q <= dy_q[VALUE_W];
        mag_q <= dy_q[VALUE_W] ? (VALUE_W+1)'(-dy_q) : dy_q;
        if (v_q == xj_q) begin
          res_q <= sext_res(yj_q);
        end else begin
          res_q <= sext_res(yi_q);
        end
      end
      S_MUL:   prod_q <= mul_p;
      S_DIV: begin
        if (div_done) begin
          res_q <= neg_q ? sext_res(yi_q) - q_ext : sext_res(yi_q) + q_ext;
        end
      end
      S_STEP1: prod_q <= mul_p;
      S_STEP2: begin
        p1_q   <= prod_q;
        prod_q <= mul_p;
      end
      S_STEP3: res_q <= $signed(step_sum[FRAC_BITS+RES_W-1:FRAC_BITS]);
      S_DONE: begin
        if (out_free) begin
          out_q.interp_value <= sat_res(res_q);
          out_q.status       <= status_q;
        end
      end
      default: ;
    endcase
  end

  // breakpoint memories, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_x[head_i.slot] <= head_i.x;
      mem_y[head_i.slot] <= head_i.y;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the table interpolator: table loads and queries against a shadow
module tb_top;
  import ti_pkg::*;

  typedef longint unsigned u64_t;

  localparam longint VMAX        = 64'sd2147483647;
  localparam longint VMIN        = -VMAX - 1;
  localparam longint VSPAN       = VMAX - VMIN;
  localparam int     FIX_ONE     = 65536;
  localparam logic   MODE_LINEAR = 1'b0;
  localparam logic   MODE_STEP   = 1'b1;
  localparam int     RANDOM_OPS  = 1350;
  localparam int     DRAIN_WAIT  = 200;
  localparam int     CYCLE_LIMIT = 2000000;
  localparam int     PRINT_CAP   = 200;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [PADDR_W-1:0]    paddr     = '0;
  logic [PDATA_W-1:0]    pwdata    = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  // shadow of the block: table contents and register settings
  logic signed [VALUE_W-1:0] tab_x [TABLE_DEPTH];
  logic signed [VALUE_W-1:0] tab_y [TABLE_DEPTH];
  logic [CNT_W-1:0]          cur_count = '0;
  logic                      cur_mode  = MODE_LINEAR;
  logic signed [VALUE_W-1:0] cur_below = '0;
  logic signed [VALUE_W-1:0] cur_above = '0;
  logic [FRAC_W-1:0]         cur_frac  = '0;

  in_item_t  table_ops [$];
  out_item_t results_due [$];
  longint    gen_x [TABLE_DEPTH];

  int mismatch_count = 0;
  int result_idx     = 0;
  int ops_queued     = 0;
  int cycle_count    = 0;
  int send_gap       = 0;
  int recv_stall     = 0;
  bit send_quiet     = 1'b0;
  bit recv_quiet     = 1'b0;

  table_interpolator uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("MISMATCH: %s", msg);
    end
  endtask

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic longint rand_upto(input longint m);
    u64_t r;
    if (m <= 0) return 0;
    r = {$urandom, $urandom};
    return longint'(r % u64_t'(m + 1));
  endfunction

  // signed Q16.16 value, now and then an extreme
  function automatic longint rand_fixed();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return VMIN;
    if (r == 1) return VMAX;
    if (r == 2) return 0;
    if (r == 3) return -1;
    return longint'($signed($urandom));
  endfunction

  // table update for a load, expected result for a query
  task automatic evaluate_item(input in_item_t it);
    longint    v, xi, xj, yi, yj, dx, dv, dy, f, t, res;
    u64_t      mag, q;
    int        n, lo, hi, mid;
    out_item_t r;
    if (op_e'(it.cmd) == OP_LOAD) begin
      tab_x[it.point_index] = it.point_x;
      tab_y[it.point_index] = it.point_y;
    end else begin
      v   = longint'($signed(it.query_value));
      n   = (cur_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(cur_count);
      res = 0;
      if (n == 0) begin
        r.status = STATUS_EMPTY;
      end else if (v < longint'(tab_x[0])) begin
        res      = cur_below;
        r.status = STATUS_BELOW;
      end else if (v > longint'(tab_x[n - 1])) begin
        res      = cur_above;
        r.status = STATUS_ABOVE;
      end else begin
        lo = 0;
        hi = n - 1;
        while (lo + 1 < hi) begin
          mid = (lo + hi) / 2;
          if (v < longint'(tab_x[mid])) hi = mid;
          else lo = mid;
        end
        xi = tab_x[lo];
        yi = tab_y[lo];
        xj = tab_x[hi];
        yj = tab_y[hi];
        if (v == xj) begin
          res = yj;
        end else if (v == xi) begin
          res = yi;
        end else if (cur_mode == MODE_LINEAR) begin
          dx = xj - xi;
          dv = v - xi;
          dy = yj - yi;
          if (dx <= 0 || dv < 0 || dv > dx) begin
            res = yi;
          end else begin
            // exact unsigned step, rounded half away from zero
            mag = (dy < 0) ? u64_t'(-dy) : u64_t'(dy);
            q   = (mag * u64_t'(dv) + (u64_t'(dx) >> 1)) / u64_t'(dx);
            res = (dy < 0) ? yi - longint'(q) : yi + longint'(q);
          end
        end else begin
          f   = (cur_frac > FRAC_ONE) ? longint'(FRAC_ONE) : longint'(cur_frac);
          t   = yi * (FIX_ONE - f) + yj * f + 32768;
          res = t >>> FRAC_BITS;
        end
        r.status = STATUS_IN_RANGE;
      end
      if (res > VMAX) res = VMAX;
      else if (res < VMIN) res = VMIN;
      r.interp_value = res[VALUE_W-1:0];
      results_due.push_back(r);
    end
  endtask

  task automatic check_output(input out_item_t got);
    out_item_t want;
    if (results_due.size() == 0) begin
      report_mismatch($sformatf("result %0d with no query pending: value %h status %0d",
                                result_idx, got.interp_value, got.status));
    end else begin
      want = results_due.pop_front();
      if (got.interp_value !== want.interp_value) begin
        report_mismatch($sformatf("result %0d interp_value %h, predicted %h",
                                  result_idx, got.interp_value, want.interp_value));
      end
      if (got.status !== want.status) begin
        report_mismatch($sformatf("result %0d status %0d, predicted %0d",
                                  result_idx, got.status, want.status));
      end
    end
    result_idx++;
  endtask

  // input side: one transaction per handshake, random gaps between them
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) evaluate_item(in_data);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (table_ops.size() > 0) begin
          in_data  <= table_ops.pop_front();
          in_valid <= 1'b1;
          send_gap <= pick_gap(send_quiet);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side: random back pressure
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_valid && out_ready) check_output(out_data);
      if (recv_stall > 0) begin
        out_ready  <= 1'b0;
        recv_stall <= recv_stall - 1;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) recv_stall <= pick_gap(recv_quiet);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // apb write, then read back the same register
  task automatic write_reg(input reg_e r, input logic [31:0] val);
    logic [31:0] mask, got;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({r, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    case (r)
      REG_POINT_COUNT: begin
        mask      = 32'h7F;
        cur_count = val[CNT_W-1:0];
      end
      REG_INTERP_MODE: begin
        mask     = 32'h1;
        cur_mode = val[0];
      end
      REG_BELOW_VALUE: begin
        mask      = 32'hFFFF_FFFF;
        cur_below = val;
      end
      REG_ABOVE_VALUE: begin
        mask      = 32'hFFFF_FFFF;
        cur_above = val;
      end
      default: begin
        mask     = 32'h1_FFFF;
        cur_frac = val[FRAC_W-1:0];
      end
    endcase
    if (got !== (val & mask)) begin
      report_mismatch($sformatf("register %s read %h after writing %h", r.name(), got, val));
    end
  endtask

  task automatic apply_cfg(input logic [31:0] count, input logic [31:0] mode,
                           input logic [31:0] below, input logic [31:0] above,
                           input logic [31:0] frac);
    write_reg(REG_POINT_COUNT, count);
    write_reg(REG_INTERP_MODE, mode);
    write_reg(REG_BELOW_VALUE, below);
    write_reg(REG_ABOVE_VALUE, above);
    write_reg(REG_STEP_FRACTION, frac);
  endtask

  task automatic push_load(input int slot, input longint x, input longint y);
    in_item_t it;
    it.cmd         = OP_LOAD;
    it.point_index = slot[5:0];
    it.point_x     = x[VALUE_W-1:0];
    it.point_y     = y[VALUE_W-1:0];
    it.query_value = $urandom;
    table_ops.push_back(it);
    ops_queued++;
  endtask

  task automatic push_query(input longint v);
    in_item_t it;
    it.cmd         = OP_QUERY;
    it.point_index = $urandom;
    it.point_x     = $urandom;
    it.point_y     = $urandom;
    it.query_value = v[VALUE_W-1:0];
    table_ops.push_back(it);
    ops_queued++;
  endtask

  // block is idle once nothing is queued, in flight or owed
  task automatic drain_block();
    while (table_ops.size() != 0 || in_valid || results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // loads slots 0..n-1 in a rotated order; shape 0 ascending, 1 with repeats, 2 scrambled
  task automatic build_table(input int n, input int shape);
    longint gap_max, xv;
    int     k, off, slot;
    gap_max = (VSPAN / n) >> $urandom_range(0, 31);
    if (gap_max < 1) gap_max = 1;
    xv = VMIN + rand_upto(VSPAN - gap_max * n);
    for (k = 0; k < n; k++) begin
      if (shape == 2) begin
        gen_x[k] = rand_fixed();
      end else begin
        gen_x[k] = xv;
        if (shape == 1 && $urandom_range(0, 3) == 0) xv = xv;
        else xv = xv + 1 + rand_upto(gap_max - 1);
      end
    end
    off = $urandom_range(0, n - 1);
    for (k = 0; k < n; k++) begin
      slot = (k + off) % n;
      push_load(slot, gen_x[slot], rand_fixed());
    end
  endtask

  task automatic random_query(input int n);
    int     k, r;
    longint v;
    k = $urandom_range(0, n - 1);
    r = $urandom_range(0, 99);
    if (r < 20) begin
      v = gen_x[k];
    end else if (r < 50) begin
      if (k + 1 < n && gen_x[k + 1] > gen_x[k]) v = gen_x[k] + rand_upto(gen_x[k + 1] - gen_x[k]);
      else v = gen_x[k];
    end else if (r < 60) begin
      v = ($urandom_range(0, 1) != 0) ? gen_x[k] + 1 : gen_x[k] - 1;
    end else if (r < 70) begin
      v = (gen_x[0] > VMIN) ? VMIN + rand_upto(gen_x[0] - 1 - VMIN) : rand_fixed();
    end else if (r < 80) begin
      v = (gen_x[n - 1] < VMAX) ? gen_x[n - 1] + 1 + rand_upto(VMAX - gen_x[n - 1] - 1)
                                : rand_fixed();
    end else begin
      v = rand_fixed();
    end
    push_query(v);
  endtask

  initial begin
    int          r, n, nq, shape, slot;
    logic [31:0] count, mode, below, above, frac;
    longint      x;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // registers at reset: empty table
    push_query(0);
    push_query(VMIN);
    drain_block();

    // two points spanning the whole range
    apply_cfg(2, MODE_LINEAR, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    push_load(0, VMIN, VMIN);
    push_load(1, VMAX, VMAX);
    push_query(0);
    push_query(VMIN);
    push_query(VMAX);
    push_query(VMIN + 1);
    push_query(-1);
    drain_block();

    // small table: outside on both sides, exact hits, rising and falling segments
    apply_cfg(4, MODE_LINEAR, 32'h1234_5678, 32'hEDCB_A987, 0);
    push_load(0, -3 * FIX_ONE, 10 * FIX_ONE);
    push_load(1, -FIX_ONE, -5 * FIX_ONE);
    push_load(2, 2 * FIX_ONE, 2 * FIX_ONE);
    push_load(3, 5 * FIX_ONE, VMAX);
    push_query(-4 * FIX_ONE);
    push_query(6 * FIX_ONE);
    push_query(-FIX_ONE);
    push_query(5 * FIX_ONE);
    push_query(-2 * FIX_ONE);
    push_query(3 * FIX_ONE + 7);
    push_query(-3 * FIX_ONE);
    drain_block();

    // constant mode at fraction zero, one, and above one
    apply_cfg(4, MODE_STEP, 0, 0, 0);
    push_query(0);
    push_query(-2 * FIX_ONE + 1);
    drain_block();
    write_reg(REG_STEP_FRACTION, FRAC_ONE);
    push_query(0);
    drain_block();
    write_reg(REG_STEP_FRACTION, 32'h1_FFFF);
    push_query(-2 * FIX_ONE);

    ops_queued = 0;
    while (ops_queued < RANDOM_OPS) begin
      drain_block();
      send_quiet = ($urandom_range(0, 3) == 0);
      recv_quiet = ($urandom_range(0, 3) == 0);

      r = $urandom_range(0, 99);
      if (r < 4) count = 0;
      else if (r < 70) count = $urandom_range(1, 8);
      else if (r < 90) count = $urandom_range(9, 63);
      else if (r < 95) count = TABLE_DEPTH;
      else count = $urandom_range(TABLE_DEPTH + 1, 127);

      r = $urandom_range(0, 99);
      if (r < 15) frac = 0;
      else if (r < 30) frac = FRAC_ONE;
      else if (r < 40) frac = $urandom_range(FRAC_ONE + 1, 32'h1_FFFF);
      else frac = $urandom_range(0, FRAC_ONE);

      mode  = $urandom_range(0, 1);
      below = 32'(rand_fixed());
      above = 32'(rand_fixed());
      // unused upper bits of the write data now and then
      if ($urandom_range(0, 4) == 0) begin
        count = count | ($urandom & ~32'h7F);
        mode  = mode | ($urandom & ~32'h1);
        frac  = frac | ($urandom & ~32'h1_FFFF);
      end
      apply_cfg(count, mode, below, above, frac);

      n = (count[CNT_W-1:0] > TABLE_DEPTH) ? TABLE_DEPTH : int'(count[CNT_W-1:0]);
      r = $urandom_range(0, 99);
      shape = (r < 80) ? 0 : (r < 92) ? 1 : 2;
      if (n > 0) build_table(n, shape);

      nq = $urandom_range(6, 30);
      repeat (nq) begin
        if ($urandom_range(0, 99) < 8) begin
          slot = $urandom_range(0, TABLE_DEPTH - 1);
          x    = rand_fixed();
          if (slot < n) gen_x[slot] = x;
          push_load(slot, x, rand_fixed());
        end
        if (n == 0) push_query(rand_fixed());
        else random_query(n);
      end
    end

    drain_block();
    if (results_due.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", results_due.size()));
    end
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
